// ----- src/plsb_pkg.sv -----
// Shared types and constants for the per-letter handler stack bank.
package plsb_pkg;

   localparam int OP_W      = 2;
   localparam int LETTER_W  = 5;
   localparam int HANDLER_W = 16;
   localparam int MASK_W    = 26;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_DROP = 2'd2
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]      operation;
      logic [LETTER_W-1:0]  letter;
      logic [HANDLER_W-1:0] handler;
      logic [MASK_W-1:0]    drop_mask;
   } req_type;

   typedef struct packed {
      logic [HANDLER_W-1:0] popped_handler;
      logic                 found;
      logic                 accepted;
   } rsp_type;

endpackage

// ----- src/plsb_ram.sv -----
// Single-port-write, single-port-read RAM with registered read data.
module plsb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 416,
   parameter int AW    = 9
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/per_letter_handler_stack_bank.sv -----
// Top level: bank of per-letter LIFO handler stacks.
//
//  channel  direction  handshake              payload
//  req_     in         req_valid / req_ready  req_type (operation, letter, handler, drop_mask)
//  rsp_     out        rsp_valid / rsp_ready  rsp_type (popped_handler, found, accepted)
//
// One beat per cycle sustained while rsp_ready stays high; a result passes through the
// registered read port of the stack RAM (the read stage) and then the response register.
// Stack counts sit in flops and update at the accept edge, so the next beat
// sees them at once; a write lands before any later read, so no forwarding.
// Synchronous reset clears the counts and both valid stages; RAM is not cleared.
// A stalled rsp_ holds one result plus one in the read stage, then req_ready drops.
module per_letter_handler_stack_bank
   import plsb_pkg::*;
#(
   parameter int LETTERS      = 26,
   parameter int STACK_DEPTH  = 16,
   parameter int HANDLER_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int DEPTH_ALL = LETTERS * STACK_DEPTH;
   localparam int AW = (DEPTH_ALL > 1) ? $clog2(DEPTH_ALL) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int LW = (LETTERS > 1) ? $clog2(LETTERS) : 1;

   logic [CW-1:0] count_ff [LETTERS];
   logic [CW-1:0] count_in [LETTERS];

   logic s1_valid_ff, s1_valid_in;
   logic s1_found_ff, s1_accepted_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic req_fire, rsp_free, s1_move;
   logic letter_ok, is_push, is_pop, is_drop, push_ok, pop_ok;
   logic [LW-1:0] sel_idx;
   logic [CW-1:0] sel_count;
   logic [AW-1:0] base_addr, wr_addr, rd_addr;
   logic [HANDLER_BITS-1:0] wr_data, rd_data;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && rsp_free;
   assign req_ready = !s1_valid_ff || rsp_free;
   assign req_fire  = req_valid && req_ready;

   assign letter_ok = req.letter < LETTER_W'(LETTERS);
   assign sel_idx   = req.letter[LW-1:0];
   assign sel_count = letter_ok ? count_ff[sel_idx] : '0;

   assign is_push = req.operation == OP_PUSH;
   assign is_pop  = req.operation == OP_POP;
   assign is_drop = req.operation == OP_DROP;
   assign push_ok = is_push && letter_ok && (sel_count != CW'(STACK_DEPTH));
   assign pop_ok  = is_pop && letter_ok && (sel_count != '0);

   assign base_addr = AW'(sel_idx) * AW'(STACK_DEPTH);
   assign wr_addr   = base_addr + AW'(sel_count);
   assign rd_addr   = base_addr + AW'(sel_count - 1'b1);
   assign wr_data   = HANDLER_BITS'(req.handler);

   plsb_ram #(
      .WIDTH (HANDLER_BITS),
      .DEPTH (DEPTH_ALL),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (req_fire && push_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_fire && pop_ok),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // per-stack count update; drop hits all masked stacks in parallel
   always_comb begin
      for (int n = 0; n < LETTERS; n++) begin
         count_in[n] = count_ff[n];
         if (req_fire) begin
            if (is_drop && req.drop_mask[n] && (count_ff[n] != '0)) begin
               count_in[n] = count_ff[n] - 1'b1;
            end
            if (push_ok && (sel_idx == LW'(n))) begin
               count_in[n] = count_ff[n] + 1'b1;
            end
            if (pop_ok && (sel_idx == LW'(n))) begin
               count_in[n] = count_ff[n] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n < LETTERS; n++) begin
         if (reset) begin
            count_ff[n] <= '0;
         end else begin
            count_ff[n] <= count_in[n];
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_found_ff    <= pop_ok;
         s1_accepted_ff <= push_ok;
      end
      if (s1_move) begin
         rsp_ff.popped_handler <= s1_found_ff ? HANDLER_W'(rd_data) : '0;
         rsp_ff.found          <= s1_found_ff;
         rsp_ff.accepted       <= s1_accepted_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- src/plsb_checker.sv -----
// Port-level checks for the handler stack bank, bound to the top level.
module plsb_checker
   import plsb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("rsp beat changed while stalled");

   // a result is never both a pop hit and a push store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp.found && rsp.accepted))
      else $error("found and accepted both set");

   // miss or non-pop returns a zero handler
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.found |-> rsp.popped_handler == '0)
      else $error("nonzero handler without a hit");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

endmodule

bind per_letter_handler_stack_bank plsb_checker u_plsb_checker (.*);
